// ----- rtl/sth_pkg.sv -----
// Shared types, widths and register codes of the segment/triangle hit unit.
package sth_pkg;

    // Internal coordinate width: holds a signed or zero-extended 32-bit value.
    localparam int CI      = 33;
    localparam int NW      = 18;   // direction and normal components
    localparam int LW      = 31;   // segment length and crossing distance
    localparam int EW      = 35;   // segment end and crossing point
    localparam int DFW     = 36;   // point minus vertex
    localparam int BW      = 34;   // vertex minus vertex
    localparam int MW      = DFW + NW;
    localparam int SW      = 56;   // plane distance sums
    localparam int DW      = 58;   // plane distance magnitudes
    localparam int RW      = 60;   // divider partial remainder
    localparam int DTW     = NW + LW + 1;
    localparam int CRW     = BW + NW + 1;
    localparam int CLO     = 27;   // low slice of the cross product
    localparam int CHI     = CRW - CLO;
    localparam int PRW     = DFW + CRW;
    localparam int TW      = PRW + 2;
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;
    localparam int QCW     = 3;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 32;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_ORIGIN_Z   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_DIR_X      = 3'd3;
    localparam logic [CFG_IW-1:0] REG_DIR_Y      = 3'd4;
    localparam logic [CFG_IW-1:0] REG_DIR_Z      = 3'd5;
    localparam logic [CFG_IW-1:0] REG_SEG_LENGTH = 3'd6;

    // Ray segment as configured.
    typedef struct packed {
        logic [2:0][CI-1:0] o;
        logic [2:0][NW-1:0] d;
        logic [LW-1:0]      len;
    } ray_t;

    // One triangle: vertices [vertex][axis] and plane normal.
    typedef struct packed {
        logic [2:0][2:0][CI-1:0] v;
        logic [2:0][NW-1:0]      n;
    } geom_t;

    // Classified triangle handed from the front to the back.
    typedef struct packed {
        logic          rej;
        logic [DW-1:0] d0;
        logic [DW-1:0] den;
        geom_t         geo;
    } qitem_t;

endpackage

// ----- rtl/sth_front.sv -----
// Front pipeline: plane distances of both segment ends and the side test.
module sth_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  sth_pkg::ray_t      ray,
    input  logic               in_valid,
    output logic               in_ready,
    input  sth_pkg::geom_t     in_geo,
    output logic               q_valid,
    output sth_pkg::qitem_t    q_item,
    input  logic               q_ready
);

    logic                             en;
    logic [4:0]                       vld_reg;
    sth_pkg::geom_t                   g1_reg, g2_reg, g3_reg, g4_reg;
    logic signed [sth_pkg::EW-1:0]    e_reg [3];
    logic signed [sth_pkg::DTW-1:0]   dl [3];
    logic signed [sth_pkg::DFW-1:0]   a0_reg [3];
    logic signed [sth_pkg::DFW-1:0]   a1_reg [3];
    logic signed [sth_pkg::MW-1:0]    m0_reg [3];
    logic signed [sth_pkg::MW-1:0]    m1_reg [3];
    logic signed [sth_pkg::SW-1:0]    s0_reg, s1_reg;
    logic signed [sth_pkg::SW-1:0]    abs0, abs1;
    logic [sth_pkg::DW-1:0]           d0, d1, den;
    sth_pkg::qitem_t                  q_reg;

    // The whole front advances unless its last stage is blocked.
    assign en       = !vld_reg[4] || q_ready;
    assign in_ready = en;
    assign q_valid  = vld_reg[4];
    assign q_item   = q_reg;

    // Segment end point, refreshed every cycle from the configuration.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dl[i] = $signed(ray.d[i]) * $signed({1'b0, ray.len});
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e_reg[i] <= sth_pkg::EW'($signed(ray.o[i])) + sth_pkg::EW'(dl[i] >>> 16);
        end
    end

    // Valid bits of the five stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // Side distances, absolute values and the rejection flag.
    always_comb
    begin
        abs0 = (s0_reg < 0) ? -s0_reg : s0_reg;
        abs1 = (s1_reg < 0) ? -s1_reg : s1_reg;
        d0   = sth_pkg::DW'($unsigned(abs0));
        d1   = sth_pkg::DW'($unsigned(abs1));
        den  = d0 + d1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_reg <= in_geo;
            g2_reg <= g1_reg;
            g3_reg <= g2_reg;
            g4_reg <= g3_reg;
            for (int i = 0; i < 3; i++)
            begin
                a0_reg[i] <= sth_pkg::DFW'($signed(ray.o[i]))
                           - sth_pkg::DFW'($signed(g1_reg.v[0][i]));
                a1_reg[i] <= sth_pkg::DFW'(e_reg[i])
                           - sth_pkg::DFW'($signed(g1_reg.v[0][i]));
                m0_reg[i] <= a0_reg[i] * $signed(g2_reg.n[i]);
                m1_reg[i] <= a1_reg[i] * $signed(g2_reg.n[i]);
            end
            s0_reg <= sth_pkg::SW'(m0_reg[0]) + sth_pkg::SW'(m0_reg[1])
                    + sth_pkg::SW'(m0_reg[2]);
            s1_reg <= sth_pkg::SW'(m1_reg[0]) + sth_pkg::SW'(m1_reg[1])
                    + sth_pkg::SW'(m1_reg[2]);
            q_reg.rej <= (s0_reg > 0 && s1_reg > 0) || (s0_reg < 0 && s1_reg < 0)
                       || (den == '0);
            q_reg.d0  <= d0;
            q_reg.den <= den;
            q_reg.geo <= g4_reg;
        end
    end

endmodule

// ----- rtl/sth_queue.sv -----
// Short queue of classified triangles between the front and the back.
module sth_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sth_pkg::qitem_t    in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output sth_pkg::qitem_t    out_item
);

    sth_pkg::qitem_t             mem [sth_pkg::QDEPTH];
    logic [sth_pkg::QAW-1:0]     wr_reg, rd_reg;
    logic [sth_pkg::QCW-1:0]     cnt_reg;
    logic                        push, pop;

    assign in_ready  = cnt_reg < sth_pkg::QCW'(sth_pkg::QDEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= in_item;
        end
    end

endmodule

// ----- rtl/sth_back.sv -----
// Back pipeline: crossing distance divider, crossing point and edge tests.
module sth_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  sth_pkg::ray_t              ray,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  sth_pkg::qitem_t            q_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_hit,
    output logic [sth_pkg::LW-1:0]     out_rem
);

    localparam int LW = sth_pkg::LW;

    logic                              en;
    logic [LW:0]                       dvld_reg;
    sth_pkg::qitem_t                   ditem_reg [LW+1];
    logic [sth_pkg::DW-1:0]            r_reg [LW+1];
    logic [LW-1:0]                     t_reg [LW+1];

    logic [6:0]                        pv_reg;
    logic                              rej_reg [7];
    logic [LW-1:0]                     tp_reg [7];
    sth_pkg::geom_t                    g1_reg, g2_reg;
    logic [2:0][sth_pkg::NW-1:0]       n3_reg;
    logic signed [sth_pkg::DTW-1:0]    dt_reg [3];
    logic signed [sth_pkg::EW-1:0]     p_reg [3];
    logic signed [sth_pkg::DFW-1:0]    a3_reg [3][3];
    logic signed [sth_pkg::BW-1:0]     b3_reg [3][3];
    logic signed [sth_pkg::DFW-1:0]    a4_reg [3][3];
    logic signed [sth_pkg::CRW-1:0]    c4_reg [3][3];
    logic signed [sth_pkg::DFW+sth_pkg::CLO:0]   mlo_reg [3][3];
    logic signed [sth_pkg::DFW+sth_pkg::CHI-1:0] mhi_reg [3][3];
    logic signed [sth_pkg::PRW-1:0]    prod_reg [3][3];
    logic [2:0]                        ok_reg;
    logic signed [sth_pkg::TW-1:0]     sum [3];

    logic                              ov_reg;
    logic                              oh_reg;
    logic [LW-1:0]                     orem_reg;

    // The back advances unless a finished result waits at the output.
    assign en        = !ov_reg || out_ready;
    assign q_ready   = en;
    assign out_valid = ov_reg;
    assign out_hit   = oh_reg;
    assign out_rem   = orem_reg;

    // Valid bits of the divider, the geometry stages and the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvld_reg <= '0;
            pv_reg   <= '0;
            ov_reg   <= 1'b0;
        end
        else if (en)
        begin
            dvld_reg <= {dvld_reg[LW-1:0], q_valid};
            pv_reg   <= {pv_reg[5:0], dvld_reg[LW]};
            ov_reg   <= pv_reg[6];
        end
    end

    // Divider entry: partial remainder and quotient start at zero.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ditem_reg[0] <= q_item;
            r_reg[0]     <= '0;
            t_reg[0]     <= '0;
        end
    end

    // One length bit per stage: remainder doubles, d0 enters, den leaves
    // up to twice, so each stage yields a quotient digit of 0, 1 or 2.
    for (genvar j = 0; j < LW; j++)
    begin : g_div
        logic [sth_pkg::RW-1:0] x, den1, den2;

        assign x    = sth_pkg::RW'({r_reg[j], 1'b0})
                    + (ray.len[LW-1-j] ? sth_pkg::RW'(ditem_reg[j].d0) : '0);
        assign den1 = sth_pkg::RW'(ditem_reg[j].den);
        assign den2 = sth_pkg::RW'({ditem_reg[j].den, 1'b0});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ditem_reg[j+1] <= ditem_reg[j];
                if (x >= den2)
                begin
                    r_reg[j+1] <= sth_pkg::DW'(x - den2);
                    t_reg[j+1] <= {t_reg[j][LW-2:0], 1'b0} + LW'(2);
                end
                else if (x >= den1)
                begin
                    r_reg[j+1] <= sth_pkg::DW'(x - den1);
                    t_reg[j+1] <= {t_reg[j][LW-2:0], 1'b1};
                end
                else
                begin
                    r_reg[j+1] <= sth_pkg::DW'(x);
                    t_reg[j+1] <= {t_reg[j][LW-2:0], 1'b0};
                end
            end
        end
    end

    // Final sums of the mixed products, one for each triangle edge.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = sth_pkg::TW'(prod_reg[k][0]) + sth_pkg::TW'(prod_reg[k][1])
                   + sth_pkg::TW'(prod_reg[k][2]);
        end
    end

    // Crossing point, edge vectors and triple products, one step per stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Flag and distance travel alongside.
            rej_reg[0] <= ditem_reg[LW].rej;
            tp_reg[0]  <= t_reg[LW];
            for (int s = 1; s < 7; s++)
            begin
                rej_reg[s] <= rej_reg[s-1];
                tp_reg[s]  <= tp_reg[s-1];
            end
            g1_reg <= ditem_reg[LW].geo;
            g2_reg <= g1_reg;
            n3_reg <= g2_reg.n;

            for (int i = 0; i < 3; i++)
            begin
                dt_reg[i] <= $signed(ray.d[i]) * $signed({1'b0, t_reg[LW]});
                p_reg[i]  <= sth_pkg::EW'($signed(ray.o[i]))
                           + sth_pkg::EW'(dt_reg[i] >>> 16);
            end

            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    int kn;
                    int i1;
                    int i2;
                    kn = (k == 2) ? 0 : k + 1;
                    i1 = (i == 2) ? 0 : i + 1;
                    i2 = (i1 == 2) ? 0 : i1 + 1;
                    a3_reg[k][i] <= sth_pkg::DFW'(p_reg[i])
                                  - sth_pkg::DFW'($signed(g2_reg.v[k][i]));
                    b3_reg[k][i] <= sth_pkg::BW'($signed(g2_reg.v[kn][i]))
                                  - sth_pkg::BW'($signed(g2_reg.v[k][i]));
                    a4_reg[k][i] <= a3_reg[k][i];
                    c4_reg[k][i] <= sth_pkg::CRW'(b3_reg[k][i1] * $signed(n3_reg[i2]))
                                  - sth_pkg::CRW'(b3_reg[k][i2] * $signed(n3_reg[i1]));
                    mlo_reg[k][i] <= a4_reg[k][i]
                                   * $signed({1'b0, c4_reg[k][i][sth_pkg::CLO-1:0]});
                    mhi_reg[k][i] <= a4_reg[k][i]
                                   * $signed(c4_reg[k][i][sth_pkg::CRW-1:sth_pkg::CLO]);
                    prod_reg[k][i] <= (sth_pkg::PRW'(mhi_reg[k][i]) <<< sth_pkg::CLO)
                                    + sth_pkg::PRW'(mlo_reg[k][i]);
                end
                ok_reg[k] <= sum[k][sth_pkg::TW-1] || (sum[k] == '0);
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oh_reg   <= !rej_reg[6] && (&ok_reg);
            orem_reg <= (!rej_reg[6] && (&ok_reg)) ? ray.len - tp_reg[6] : '0;
        end
    end

endmodule

// ----- rtl/segment_triangle_hit_unit.sv -----
// Top level of the segment/triangle hit unit: registers, ports and the two halves.
//
//  channel   direction  handshake               payload
//  s_axis    in         s_axis_tvalid/tready    triangle: 3 vertices and normal
//  m_axis    out        m_axis_tvalid/tready    hit flag and remaining length
//  cfg       in         cfg_valid/cfg_ready     register index and data
//
// One triangle is taken every cycle while s_axis_tready is high; each result
// goes through the front, queue, 31-stage crossing distance divider and geometry.
// Reset clears all valid bits, queue pointers and the configuration registers.
// A stalled output freezes the back; the four-entry queue lets the front accept
// until it fills and the front's last stage is occupied; then s_axis_tready falls.
module segment_triangle_hit_unit
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z (32 each),
    // norm_x, norm_y, norm_z (18 each), 2 zero bits
    input  logic [343:0]                 s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // hit (1), remaining_length (31)
    output logic [31:0]                  m_axis_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sth_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [sth_pkg::CFG_DW-1:0]   cfg_data
);

    localparam int SHAMT = (COORD_WIDTH > 32) ? 0 : 32 - COORD_WIDTH;

    logic [31:0]                origin_reg [3];
    logic [sth_pkg::NW-1:0]     dir_reg [3];
    logic [sth_pkg::LW-1:0]     len_reg;
    sth_pkg::ray_t              ray;
    sth_pkg::geom_t             in_geo;
    logic                       fq_valid, fq_ready, qb_valid, qb_ready;
    sth_pkg::qitem_t            fq_item, qb_item;
    logic                       hit;
    logic [sth_pkg::LW-1:0]     rem;

    // Coordinates read as COORD_WIDTH-bit two's complement; wider reads unsigned.
    function automatic logic [sth_pkg::CI-1:0] ext_coord(input logic [31:0] raw);
        logic signed [31:0] sh;
        sh = $signed(raw << SHAMT) >>> SHAMT;
        if (COORD_WIDTH > 32)
        begin
            return {1'b0, raw};
        end
        return {sh[31], sh};
    endfunction

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                origin_reg[i] <= '0;
                dir_reg[i]    <= '0;
            end
            len_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sth_pkg::REG_ORIGIN_X:   origin_reg[0] <= cfg_data;
                sth_pkg::REG_ORIGIN_Y:   origin_reg[1] <= cfg_data;
                sth_pkg::REG_ORIGIN_Z:   origin_reg[2] <= cfg_data;
                sth_pkg::REG_DIR_X:      dir_reg[0]    <= cfg_data[sth_pkg::NW-1:0];
                sth_pkg::REG_DIR_Y:      dir_reg[1]    <= cfg_data[sth_pkg::NW-1:0];
                sth_pkg::REG_DIR_Z:      dir_reg[2]    <= cfg_data[sth_pkg::NW-1:0];
                sth_pkg::REG_SEG_LENGTH: len_reg       <= cfg_data[sth_pkg::LW-1:0];
                default:                 ;
            endcase
        end
    end

    // Unpack the ray and the incoming triangle.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ray.o[i]    = ext_coord(origin_reg[i]);
            ray.d[i]    = dir_reg[i];
            in_geo.n[i] = s_axis_tdata[288 + i*sth_pkg::NW +: sth_pkg::NW];
            for (int k = 0; k < 3; k++)
            begin
                in_geo.v[k][i] = ext_coord(s_axis_tdata[(k*3 + i)*32 +: 32]);
            end
        end
        ray.len = len_reg;
    end

    sth_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ray      (ray),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_geo   (in_geo),
        .q_valid  (fq_valid),
        .q_item   (fq_item),
        .q_ready  (fq_ready)
    );

    sth_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    sth_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray       (ray),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_item    (qb_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hit   (hit),
        .out_rem   (rem)
    );

    assign m_axis_tdata = {rem, hit};

endmodule
